// ----- design/tsfe_pkg.sv -----
// ----------------------------------------------------------------------------
// tsfe_pkg
// Shared types and constants for the strip/fan to triangle list expander.
// ----------------------------------------------------------------------------
package tsfe_pkg;

    localparam int INDEX_WIDTH  = 32;
    localparam int CFG_WIDTH    = 32;
    localparam int CFG_IDX_W    = 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = QUEUE_PTR_W + 1;
    localparam int TRI_VERTS    = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ASSEMBLY_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_OFFSET  = 1'b1;

    // assembly modes (code three behaves as list)
    localparam logic [1:0] MODE_LIST  = 2'd0;
    localparam logic [1:0] MODE_STRIP = 2'd1;
    localparam logic [1:0] MODE_FAN   = 2'd2;

    // last slot of a command: one index or a full triangle
    localparam logic [1:0] POS_SINGLE   = 2'd0;
    localparam logic [1:0] POS_TRIANGLE = 2'd2;

    localparam logic [1:0] SEEN_FULL = 2'd2;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] vertex_index;
        logic                   primitive_start;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] out_index;
        logic                   run_last;
    } result_t;

    // one classified input: up to three indices to emit
    typedef struct packed {
        logic [1:0]                            last_pos;
        logic [TRI_VERTS-1:0][INDEX_WIDTH-1:0] idx;
    } cmd_t;

endpackage

// ----- design/triangle_strip_fan_expander_top.sv -----
// ----------------------------------------------------------------------------
// triangle_strip_fan_expander_top
// Expands indexed triangle strips and fans into a flat triangle list.
// ----------------------------------------------------------------------------
//  Channel   Ports                                  Transfer when
//  -------   -------------------------------------  ---------------------------
//  item      item_valid / item_ready / item         item_valid & item_ready
//  result    result_valid / result_ready / result   result_valid & result_ready
//  config    wr_en / wr_index / wr_data             wr_en (no wait, no readback)
//
//  Rate: one result leaves per cycle from the output register while result_ready
//  holds. List mode sustains one index per cycle; a strip or fan triangle leaves
//  as its three indices in turn through the single output port of the serializer.
//  Path: an input's command is written into the command queue at its transfer;
//  its first index then moves into the output register, which drives result_valid.
//  Stalls: a two-entry command queue lets the front keep taking indices
//  while the back waits on result_ready; item_ready drops only when full.
//  Reset: rst_n clears config, history and queue; no clearing pass.
// ----------------------------------------------------------------------------
module triangle_strip_fan_expander_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  tsfe_pkg::in_item_t             item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output tsfe_pkg::result_t              result,
    input  logic                           wr_en,
    input  logic [tsfe_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [tsfe_pkg::CFG_WIDTH-1:0] wr_data
);
    import tsfe_pkg::*;

    // front -> queue
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;

    // queue -> back
    logic pop_valid;
    logic pop;
    cmd_t pop_cmd;

    // offset add, history and classification
    tsfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // decouples classification from output stalls
    tsfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_cmd    (pop_cmd)
    );

    // one index per cycle into the output register while result_ready allows
    tsfe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop          (pop),
        .pop_cmd      (pop_cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ----- design/tsfe_front.sv -----
// ----------------------------------------------------------------------------
// tsfe_front
// Accepts indices, applies the offset, tracks primitive history and
// classifies each index into an emit command.
// ----------------------------------------------------------------------------
module tsfe_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  tsfe_pkg::in_item_t           item,
    input  logic                         wr_en,
    input  logic [tsfe_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [tsfe_pkg::CFG_WIDTH-1:0] wr_data,
    output logic                         push_valid,
    input  logic                         push_ready,
    output tsfe_pkg::cmd_t               push_cmd
);
    import tsfe_pkg::*;

    logic [1:0]             mode_reg;
    logic [INDEX_WIDTH-1:0] offset_reg;
    logic [INDEX_WIDTH-1:0] center_reg, center_next;
    logic [INDEX_WIDTH-1:0] older_reg;
    logic [INDEX_WIDTH-1:0] newer_reg;
    logic [1:0]             seen_reg, seen_next;
    logic                   odd_reg, odd_next;

    logic [INDEX_WIDTH-1:0] v;
    logic [1:0]             seen_eff;
    logic                   odd_eff;
    logic                   emit;
    logic                   accept;

    assign v        = item.vertex_index + offset_reg;
    assign seen_eff = item.primitive_start ? 2'd0 : seen_reg;
    assign odd_eff  = item.primitive_start ? 1'b0 : odd_reg;
    assign center_next = (seen_eff == 2'd0) ? v : center_reg;
    assign seen_next   = (seen_eff == SEEN_FULL) ? SEEN_FULL : seen_eff + 2'd1;

    always_comb
    begin
        emit            = 1'b0;
        odd_next        = odd_eff;
        push_cmd.last_pos = POS_TRIANGLE;
        push_cmd.idx[0] = center_next;
        push_cmd.idx[1] = newer_reg;
        push_cmd.idx[2] = v;
        case (mode_reg)
            MODE_STRIP:
            begin
                if (seen_eff == SEEN_FULL)
                begin
                    emit            = 1'b1;
                    push_cmd.idx[0] = odd_eff ? newer_reg : older_reg;
                    push_cmd.idx[1] = odd_eff ? older_reg : newer_reg;
                    odd_next        = ~odd_eff;
                end
            end
            MODE_FAN:
            begin
                emit = (seen_eff == SEEN_FULL);
            end
            default:
            begin
                emit              = 1'b1;
                push_cmd.last_pos = POS_SINGLE;
                push_cmd.idx[0]   = v;
            end
        endcase
    end

    assign item_ready = push_ready;
    assign accept     = item_valid && push_ready;
    assign push_valid = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_LIST;
            offset_reg <= '0;
            center_reg <= '0;
            older_reg  <= '0;
            newer_reg  <= '0;
            seen_reg   <= '0;
            odd_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_ASSEMBLY_MODE: mode_reg   <= wr_data[1:0];
                    REG_INDEX_OFFSET:  offset_reg <= wr_data[INDEX_WIDTH-1:0];
                    default:           ;
                endcase
            end
            if (accept)
            begin
                center_reg <= center_next;
                older_reg  <= newer_reg;
                newer_reg  <= v;
                seen_reg   <= seen_next;
                odd_reg    <= odd_next;
            end
        end
    end

endmodule

// ----- design/tsfe_queue.sv -----
// ----------------------------------------------------------------------------
// tsfe_queue
// Short command queue between the classifier and the serializer.
// ----------------------------------------------------------------------------
module tsfe_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  tsfe_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop,
    output tsfe_pkg::cmd_t pop_cmd
);
    import tsfe_pkg::*;

    cmd_t                   entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/tsfe_back.sv -----
// ----------------------------------------------------------------------------
// tsfe_back
// Serializes queued commands, one registered result per cycle unless stalled.
// ----------------------------------------------------------------------------
module tsfe_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop,
    input  tsfe_pkg::cmd_t    pop_cmd,
    output logic              result_valid,
    input  logic              result_ready,
    output tsfe_pkg::result_t result
);
    import tsfe_pkg::*;

    logic       valid_reg, valid_next;
    result_t    data_reg, data_next;
    logic [1:0] pos_reg, pos_next;
    logic       load;
    logic       last;

    assign load = !valid_reg || result_ready;
    assign last = (pos_reg == pop_cmd.last_pos);
    assign pop  = load && pop_valid && last;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        pos_next   = pos_reg;
        if (load)
        begin
            valid_next = pop_valid;
            if (pop_valid)
            begin
                data_next.out_index = pop_cmd.idx[pos_reg];
                data_next.run_last  = last;
                pos_next            = last ? 2'd0 : pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

// ----- tb/sv/tb_triangle_strip_fan_expander_top.sv -----
// ----------------------------------------------------------------------------
// tb_triangle_strip_fan_expander_top
// Self-checking bench for the strip/fan to triangle list expander. A behavioral
// copy of the index history predicts every output transfer. Directed cases
// cover list, strip, fan and the spare mode code, offset wrap and mid-primitive
// changes. Random primitives follow, with backpressure and idle gaps on both
// channels.
// ----------------------------------------------------------------------------
module tb_triangle_strip_fan_expander_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tsfe_pkg::*;

    localparam int         CLK_HALF      = 6;     // 12 ns period
    localparam int         RESET_CYCLES  = 10;
    localparam int         SETTLE_CYCLES = 6;
    localparam int         QUIET_LIMIT   = 2000;  // cycles without any transfer
    localparam int         TARGET_ITEMS  = 450;
    localparam int         MAX_REPORTS   = 10;
    localparam int         HOLD_CYCLES   = 120;   // long receiver hold-off
    localparam logic [1:0] MODE_SPARE    = 2'd3;  // unused code, acts as list

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_ready;
    in_item_t             item         = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result;
    logic                 wr_en        = 1'b0;
    logic [CFG_IDX_W-1:0] wr_index     = '0;
    logic [CFG_WIDTH-1:0] wr_data      = '0;

    triangle_strip_fan_expander_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor state: configuration shadow plus the vertex history
    // ------------------------------------------------------------------------
    logic [1:0]             pred_mode   = MODE_LIST;
    logic [INDEX_WIDTH-1:0] pred_offset = '0;
    logic [INDEX_WIDTH-1:0] hist_center = '0;
    logic [INDEX_WIDTH-1:0] hist_old    = '0;
    logic [INDEX_WIDTH-1:0] hist_new    = '0;
    logic [1:0]             hist_count  = '0;
    logic                   strip_odd   = 1'b0;

    result_t predicted_indices[$];   // triangle list indices still to come out

    int  index_transfers  = 0;
    int  result_transfers = 0;
    int  config_writes    = 0;
    int  mismatches       = 0;
    int  triangles_seen   = 0;
    int  items_per_mode[4];
    int  quiet_cycles     = 0;
    int  hold_left        = 0;       // receiver hold-off, counted down below
    bit  tx_gap_en        = 1'b1;
    bit  rx_stall_en      = 1'b1;

    task automatic push_index(input logic [INDEX_WIDTH-1:0] vidx, input logic last);
        result_t r;
        r.out_index = vidx;
        r.run_last  = last;
        predicted_indices = {predicted_indices, r};
    endtask

    // One accepted index: offset it, update history, queue what it emits.
    task automatic assemble_index(input in_item_t beat);
        logic [INDEX_WIDTH-1:0] v;
        v = beat.vertex_index + pred_offset;   // wraps at 2^32
        if (beat.primitive_start)
        begin
            hist_count = '0;
            strip_odd  = 1'b0;
        end
        if (hist_count == '0)
            hist_center = v;

        case (pred_mode)
            MODE_STRIP:
            begin
                if (hist_count == SEEN_FULL)
                begin
                    // odd triangles swap the first two to keep the winding
                    push_index(strip_odd ? hist_new : hist_old, 1'b0);
                    push_index(strip_odd ? hist_old : hist_new, 1'b0);
                    push_index(v, 1'b1);
                    strip_odd = ~strip_odd;
                    triangles_seen++;
                end
            end
            MODE_FAN:
            begin
                if (hist_count == SEEN_FULL)
                begin
                    push_index(hist_center, 1'b0);
                    push_index(hist_new, 1'b0);
                    push_index(v, 1'b1);
                    triangles_seen++;
                end
            end
            default:
                push_index(v, 1'b1);    // list and the spare code pass through
        endcase

        hist_old = hist_new;
        hist_new = v;
        if (hist_count != SEEN_FULL)
            hist_count = hist_count + 2'd1;
    endtask

    // ------------------------------------------------------------------------
    // Result checker: each result transfer against the oldest prediction
    // ------------------------------------------------------------------------
    task automatic note_mismatch(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: expected index %h last %b, got index %h last %b",
                     $realtime, what, want.out_index, want.run_last,
                     got.out_index, got.run_last);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            result_transfers++;
            if (predicted_indices.size() == 0)
                note_mismatch("result with nothing pending", '0, result);
            else
            begin
                want = predicted_indices.pop_front();
                if (result.out_index !== want.out_index)
                    note_mismatch("out_index mismatch", want, result);
                else if (result.run_last !== want.run_last)
                    note_mismatch("run_last mismatch", want, result);
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when a test asks for one.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left    = hold_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= !(rx_stall_en && $urandom_range(99) < 30);
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     QUIET_LIMIT, predicted_indices.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers; every task starts and ends right after a rising edge
    // ------------------------------------------------------------------------
    task automatic send_index(input logic [INDEX_WIDTH-1:0] vidx, input logic first);
        in_item_t beat;
        beat.vertex_index    = vidx;
        beat.primitive_start = first;
        item       <= beat;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        assemble_index(beat);
        index_transfers++;
        items_per_mode[pred_mode]++;
        if (tx_gap_en && $urandom_range(99) < 30)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Stop offering, wait until every predicted result is out, then let any
    // index that emitted nothing clear the pipeline.
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (predicted_indices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_WIDTH-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= sel;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        case (sel)
            REG_ASSEMBLY_MODE: pred_mode   = data[1:0];
            REG_INDEX_OFFSET:  pred_offset = data[INDEX_WIDTH-1:0];
            default: ;
        endcase
        config_writes++;
        @(posedge clk);
    endtask

    function automatic logic [INDEX_WIDTH-1:0] pick_index();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return INDEX_WIDTH'($urandom_range(255));
            default: return INDEX_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_WIDTH-1:0] pick_offset();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return CFG_WIDTH'($urandom_range(1024));
            default: return CFG_WIDTH'($urandom);
        endcase
    endfunction

    // Mostly well-formed primitives; now and then a missing or stray start.
    task automatic send_random_primitive(input int len);
        for (int k = 0; k < len; k++)
        begin
            logic first;
            first = (k == 0) ? ($urandom_range(19) != 0) : ($urandom_range(29) == 0);
            send_index(pick_index(), first);
        end
    endtask

    task automatic run_random_phase(input int n_items);
        int                   sent;
        logic [1:0]           mode;
        logic [CFG_WIDTH-1:0] mode_word;
        sent = 0;
        case ($urandom_range(9))
            0, 1, 2, 3: mode = MODE_STRIP;
            4, 5, 6, 7: mode = MODE_FAN;
            8:          mode = MODE_LIST;
            default:    mode = MODE_SPARE;
        endcase
        // upper bits of the mode word are don't-care
        mode_word = CFG_WIDTH'(mode);
        if ($urandom_range(3) == 0)
            mode_word = (CFG_WIDTH'($urandom) & ~CFG_WIDTH'(3)) | CFG_WIDTH'(mode);

        wait_drained();
        write_reg(REG_ASSEMBLY_MODE, mode_word);
        if ($urandom_range(3) != 0)
            write_reg(REG_INDEX_OFFSET, pick_offset());

        while (sent < n_items)
        begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
            if (len > n_items - sent)
                len = n_items - sent;
            send_random_primitive(len);
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // History is zero after reset; a stream with no start flag still works.
    task automatic test_strip_without_start();
        write_reg(REG_ASSEMBLY_MODE, CFG_WIDTH'(MODE_STRIP));
        send_index(32'd5, 1'b0);
        send_index(32'd6, 1'b0);
        send_index(32'd7, 1'b0);
    endtask

    task automatic test_list_extremes();
        wait_drained();
        write_reg(REG_ASSEMBLY_MODE, CFG_WIDTH'(MODE_LIST));
        send_index('0, 1'b1);
        send_index('1, 1'b0);
    endtask

    // All-ones offset wraps every index down by one.
    task automatic test_offset_wrap();
        wait_drained();
        write_reg(REG_INDEX_OFFSET, '1);
        send_index('0, 1'b0);
        send_index(32'd1, 1'b0);
        send_index('1, 1'b0);
    endtask

    // Alternating winding, then primitives too short to emit anything.
    task automatic test_strip_winding();
        wait_drained();
        write_reg(REG_ASSEMBLY_MODE, CFG_WIDTH'(MODE_STRIP));
        write_reg(REG_INDEX_OFFSET, CFG_WIDTH'(16));
        for (int k = 1; k <= 5; k++)
            send_index(INDEX_WIDTH'(k), k == 1);
        send_index(32'd7, 1'b1);
        send_index(32'd8, 1'b0);
        send_index(32'd9, 1'b1);
    endtask

    task automatic test_fan_center();
        wait_drained();
        write_reg(REG_ASSEMBLY_MODE, CFG_WIDTH'(MODE_FAN));
        write_reg(REG_INDEX_OFFSET, 32'h8000_0000);
        for (int k = 0; k < 4; k++)
            send_index(INDEX_WIDTH'(100 + k), k == 0);
    endtask

    // Code three with every upper bit set behaves as list.
    task automatic test_spare_mode();
        wait_drained();
        write_reg(REG_ASSEMBLY_MODE, '1);
        send_index(32'd9, 1'b1);
        send_index(32'hA5A5_5A5A, 1'b0);
    endtask

    // Offset and mode change in the middle of a primitive; history stays.
    task automatic test_midstream_changes();
        wait_drained();
        write_reg(REG_ASSEMBLY_MODE, CFG_WIDTH'(MODE_STRIP));
        send_index(32'd20, 1'b1);
        send_index(32'd21, 1'b0);
        send_index(32'd22, 1'b0);
        wait_drained();
        write_reg(REG_INDEX_OFFSET, CFG_WIDTH'(1000));
        send_index(32'd23, 1'b0);
        wait_drained();
        write_reg(REG_ASSEMBLY_MODE, CFG_WIDTH'(MODE_FAN));
        send_index(32'd24, 1'b0);
    endtask

    // Receiver holds off while the sender keeps offering back to back:
    // the command queue fills and item_ready has to drop.
    task automatic test_backpressure();
        wait_drained();
        write_reg(REG_ASSEMBLY_MODE, CFG_WIDTH'(MODE_STRIP));
        tx_gap_en = 1'b0;
        hold_left = HOLD_CYCLES;
        for (int k = 0; k < 20; k++)
            send_index(pick_index(), k % 6 == 0);
        tx_gap_en = 1'b1;
    endtask

    // Random phases; the third one runs with no idling on either side.
    task automatic test_random_traffic();
        int phase;
        phase = 0;
        while (index_transfers < TARGET_ITEMS)
        begin
            if (phase == 2)
            begin
                tx_gap_en   = 1'b0;
                rx_stall_en = 1'b0;
                run_random_phase(60);
                tx_gap_en   = 1'b1;
                rx_stall_en = 1'b1;
            end
            else
                run_random_phase($urandom_range(20, 50));
            phase++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_strip_without_start();
        test_list_extremes();
        test_offset_wrap();
        test_strip_winding();
        test_fan_center();
        test_spare_mode();
        test_midstream_changes();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        if (predicted_indices.size() != 0)
        begin
            mismatches += predicted_indices.size();
            $display("%0d predicted results never arrived", predicted_indices.size());
        end

        $display("Sent %0d indices (list %0d, strip %0d, fan %0d, spare code %0d), %0d reg writes",
                 index_transfers, items_per_mode[MODE_LIST], items_per_mode[MODE_STRIP],
                 items_per_mode[MODE_FAN], items_per_mode[MODE_SPARE], config_writes);
        $display("Checked %0d output indices, %0d triangles, %0d mismatches",
                 result_transfers, triangles_seen, mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
design/tsfe_pkg.sv
design/tsfe_front.sv
design/tsfe_queue.sv
design/tsfe_back.sv
design/triangle_strip_fan_expander_top.sv
tb/sv/tb_triangle_strip_fan_expander_top.sv
